// ----- rtl/tlbpt_pkg.sv -----
// Shared widths and controller/datapath handshake types for the TLB block.
`timescale 1ns / 1ps

package tlbpt_pkg;

    // Fixed widths of the request and response fields
    localparam int VPN_IN_W    = 16;
    localparam int FRAME_OUT_W = 8;

    // Per-cycle commands from the controller to the datapath
    typedef struct packed {
        logic clr;     // reset-time clearing write at the sweep index
        logic load;    // capture a request and clear the per-lookup flags
        logic tlb_rd;  // read the next TLB way of the set
        logic tlb_wb;  // compare and age the way read last cycle
        logic pt_rd;   // read the page table entry of the request
        logic pt_chk;  // take the page table answer
        logic fr_rd;   // read the next frame record
        logic fr_wb;   // allocate or age the frame read last cycle
        logic evict;   // evict the oldest frame when none was free
        logic fill;    // refill the TLB victim, map the page on a fault
    } t_cmd;

    // Status back to the controller
    typedef struct packed {
        logic clr_last;
        logic way_done;
        logic frame_done;
        logic tlb_hit;
        logic pt_hit;
    } t_sts;

endpackage

// ----- rtl/tlbpt_if.sv -----
// Request and response channel interfaces of the TLB block.
`timescale 1ns / 1ps

interface tlbpt_req_if;
    logic                             valid;
    logic                             ready;
    logic [tlbpt_pkg::VPN_IN_W-1:0]   vpn;

    modport source (output valid, output vpn, input ready);
    modport sink   (input valid, input vpn, output ready);
endinterface

interface tlbpt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [tlbpt_pkg::FRAME_OUT_W-1:0]  frame;
    logic                               tlb_hit;
    logic                               walk_hit;
    logic                               page_fault;

    modport source (output valid, output frame, output tlb_hit, output walk_hit,
                    output page_fault, input ready);
    modport sink   (input valid, input frame, input tlb_hit, input walk_hit,
                    input page_fault, output ready);
endinterface

// ----- rtl/tlbpt_ctrl.sv -----
// Sequencing state machine of the TLB block: clear pass, lookup, table walk, refill.
`timescale 1ns / 1ps

module tlbpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tlbpt_pkg::t_sts   i_sts,
    output tlbpt_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_TLB      = 4'd2;
    localparam logic [3:0] S_TLB_DONE = 4'd3;
    localparam logic [3:0] S_PT_CHK   = 4'd4;
    localparam logic [3:0] S_FRAME    = 4'd5;
    localparam logic [3:0] S_EVICT    = 4'd6;
    localparam logic [3:0] S_FILL     = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_pend, n_pend;   // a memory read is in flight

    // State and read-pending registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_pend      = 1'b0;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TLB;
                end
            end
            S_TLB: begin
                o_cmd.tlb_rd = !i_sts.way_done;
                o_cmd.tlb_wb = r_pend;
                n_pend       = o_cmd.tlb_rd;
                if (i_sts.way_done && r_pend) n_state = S_TLB_DONE;
            end
            S_TLB_DONE: begin
                if (i_sts.tlb_hit) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.pt_rd = 1'b1;
                    n_state     = S_PT_CHK;
                end
            end
            S_PT_CHK: begin
                o_cmd.pt_chk = 1'b1;
                n_state      = i_sts.pt_hit ? S_FILL : S_FRAME;
            end
            S_FRAME: begin
                o_cmd.fr_rd = !i_sts.frame_done;
                o_cmd.fr_wb = r_pend;
                n_pend      = o_cmd.fr_rd;
                if (i_sts.frame_done && r_pend) n_state = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/tlbpt_dp.sv -----
// Datapath of the TLB block: TLB, page table and frame table memories with scan logic.
`timescale 1ns / 1ps

module tlbpt_dp #(
    parameter int VPN_BITS = 16,
    parameter int SET_BITS = 4,
    parameter int WAYS     = 4,
    parameter int FRAMES   = 256,
    parameter int AGE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [tlbpt_pkg::VPN_IN_W-1:0]       i_vpn,
    input  tlbpt_pkg::t_cmd                      i_cmd,
    output tlbpt_pkg::t_sts                      o_sts,
    output logic [tlbpt_pkg::FRAME_OUT_W-1:0]    o_frame,
    output logic                                 o_tlb_hit,
    output logic                                 o_walk_hit,
    output logic                                 o_page_fault
);

    localparam int SETS      = 1 << SET_BITS;
    localparam int TLB_DEPTH = SETS * WAYS;
    localparam int TLB_AW    = $clog2(TLB_DEPTH);
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W     = (VPN_BITS > SET_BITS) ? (VPN_BITS - SET_BITS) : 1;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int PT_DEPTH  = 1 << VPN_BITS;
    localparam int CLR_A     = (PT_DEPTH > FRAMES) ? PT_DEPTH : FRAMES;
    localparam int CLR_DEPTH = (CLR_A > TLB_DEPTH) ? CLR_A : TLB_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int CNT_W     = CLR_W + 1;

    typedef struct packed {
        logic                v;
        logic [TAG_W-1:0]    tag;
        logic [FRAME_W-1:0]  frame;
        logic [AGE_BITS-1:0] age;
    } t_tlb_ent;

    typedef struct packed {
        logic               v;
        logic [FRAME_W-1:0] frame;
    } t_pt_ent;

    typedef struct packed {
        logic                free;
        logic [VPN_BITS-1:0] owner;
        logic [AGE_BITS-1:0] age;
    } t_fr_ent;

    function automatic logic [AGE_BITS-1:0] f_age_inc(input logic [AGE_BITS-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    // Memories and their registered read data
    t_tlb_ent r_tlb_mem [TLB_DEPTH];
    t_pt_ent  r_pt_mem  [PT_DEPTH];
    t_fr_ent  r_fr_mem  [FRAMES];
    t_tlb_ent r_tlb_q;
    t_pt_ent  r_pt_q;
    t_fr_ent  r_fr_q;

    // Lookup state
    logic [VPN_BITS-1:0] r_vpn;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_pidx;
    logic                r_hit, r_thit, r_fault, r_placed, r_hv, r_hp;
    logic [AGE_BITS-1:0] r_best, r_fbest;
    logic [WAY_W-1:0]    r_victim;
    logic [FRAME_W-1:0]  r_pick;
    logic [VPN_BITS-1:0] r_powner;
    logic [FRAME_W-1:0]  r_frame;

    logic [SET_BITS-1:0] set_idx;
    logic [TAG_W-1:0]    tag;
    logic [WAY_W-1:0]    wb_way;
    logic [FRAME_W-1:0]  wb_frame;
    logic                way_hit, fr_take;
    logic [AGE_BITS-1:0] tlb_aged;
    logic [TLB_AW-1:0]   tlb_ra, tlb_wa;
    logic                tlb_we, pt_we, fr_we;
    t_tlb_ent            tlb_wd;
    logic [VPN_BITS-1:0] pt_wa;
    t_pt_ent             pt_wd;
    logic [FRAME_W-1:0]  fr_wa;
    t_fr_ent             fr_wd;

    assign set_idx  = r_vpn[SET_BITS-1:0];
    assign tag      = TAG_W'(r_vpn >> SET_BITS);
    assign wb_way   = r_pidx[WAY_W-1:0];
    assign wb_frame = r_pidx[FRAME_W-1:0];
    assign tlb_ra   = TLB_AW'(32'(set_idx) * WAYS + 32'(r_idx[WAY_W-1:0]));

    // Way compare and aging of the way read last cycle
    assign way_hit  = !r_hit && r_tlb_q.v && (r_tlb_q.tag == tag);
    assign tlb_aged = f_age_inc(r_tlb_q.age);
    assign fr_take  = r_fr_q.free && !r_placed;

    // TLB write port
    always_comb begin
        tlb_we = 1'b0;
        tlb_wa = tlb_ra;
        tlb_wd = r_tlb_q;
        if (i_cmd.clr) begin
            tlb_we = (r_idx < CNT_W'(TLB_DEPTH));
            tlb_wa = r_idx[TLB_AW-1:0];
            tlb_wd = '0;
        end else if (i_cmd.tlb_wb) begin
            tlb_we     = 1'b1;
            tlb_wa     = TLB_AW'(32'(set_idx) * WAYS + 32'(wb_way));
            tlb_wd.age = way_hit ? '0 : tlb_aged;
        end else if (i_cmd.fill) begin
            tlb_we       = 1'b1;
            tlb_wa       = TLB_AW'(32'(set_idx) * WAYS + 32'(r_victim));
            tlb_wd.v     = 1'b1;
            tlb_wd.tag   = tag;
            tlb_wd.frame = r_frame;
            tlb_wd.age   = '0;
        end
    end

    // Page table write port
    always_comb begin
        pt_we = 1'b0;
        pt_wa = r_vpn;
        pt_wd = '0;
        if (i_cmd.clr) begin
            pt_we = (r_idx < CNT_W'(PT_DEPTH));
            pt_wa = r_idx[VPN_BITS-1:0];
        end else if (i_cmd.evict) begin
            // drop the evicted frame's old mapping
            pt_we = !r_placed;
            pt_wa = r_powner;
        end else if (i_cmd.fill) begin
            pt_we       = r_fault;
            pt_wd.v     = 1'b1;
            pt_wd.frame = r_frame;
        end
    end

    // Frame table write port
    always_comb begin
        fr_we = 1'b0;
        fr_wa = wb_frame;
        fr_wd = r_fr_q;
        if (i_cmd.clr) begin
            fr_we      = (r_idx < CNT_W'(FRAMES));
            fr_wa      = r_idx[FRAME_W-1:0];
            fr_wd      = '0;
            fr_wd.free = 1'b1;
        end else if (i_cmd.fr_wb) begin
            fr_we = 1'b1;
            if (fr_take) begin
                fr_wd.free  = 1'b0;
                fr_wd.owner = r_vpn;
                fr_wd.age   = '0;
            end else begin
                fr_wd.age = f_age_inc(r_fr_q.age);
            end
        end else if (i_cmd.evict) begin
            fr_we       = !r_placed;
            fr_wa       = r_pick;
            fr_wd.free  = 1'b0;
            fr_wd.owner = r_vpn;
            fr_wd.age   = '0;
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (tlb_we) r_tlb_mem[tlb_wa] <= tlb_wd;
        if (i_cmd.tlb_rd) r_tlb_q <= r_tlb_mem[tlb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) r_pt_mem[pt_wa] <= pt_wd;
        if (i_cmd.pt_rd) r_pt_q <= r_pt_mem[r_vpn];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) r_fr_mem[fr_wa] <= fr_wd;
        if (i_cmd.fr_rd) r_fr_q <= r_fr_mem[r_idx[FRAME_W-1:0]];
    end

    // Sweep and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load || i_cmd.pt_rd) begin
            r_idx <= '0;
        end else if (i_cmd.clr || i_cmd.tlb_rd || i_cmd.fr_rd) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Lookup flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit    <= 1'b0;
            r_thit   <= 1'b0;
            r_fault  <= 1'b0;
            r_placed <= 1'b0;
            r_hv     <= 1'b0;
            r_hp     <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit    <= 1'b0;
            r_thit   <= 1'b0;
            r_fault  <= 1'b0;
            r_placed <= 1'b0;
            r_hv     <= 1'b0;
            r_hp     <= 1'b0;
        end else begin
            if (i_cmd.tlb_wb) begin
                if (way_hit) r_hit <= 1'b1;
                else if (!r_hv || tlb_aged > r_best) r_hv <= 1'b1;
            end
            if (i_cmd.pt_chk) begin
                r_thit  <= r_pt_q.v;
                r_fault <= !r_pt_q.v;
            end
            if (i_cmd.fr_wb) begin
                if (fr_take) r_placed <= 1'b1;
                else if (!r_hp || r_fr_q.age > r_fbest) r_hp <= 1'b1;
            end
        end
    end

    // Lookup payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_vpn <= VPN_BITS'(i_vpn);
        if (i_cmd.tlb_rd || i_cmd.fr_rd) r_pidx <= r_idx;
        if (i_cmd.tlb_wb) begin
            if (way_hit) begin
                r_frame <= r_tlb_q.frame;
            end else if (!r_hv || tlb_aged > r_best) begin
                r_best   <= tlb_aged;
                r_victim <= wb_way;
            end
        end
        if (i_cmd.pt_chk && r_pt_q.v) r_frame <= r_pt_q.frame;
        if (i_cmd.fr_wb) begin
            if (fr_take) begin
                r_frame <= wb_frame;
            end else if (!r_hp || r_fr_q.age > r_fbest) begin
                r_fbest  <= r_fr_q.age;
                r_pick   <= wb_frame;
                r_powner <= r_fr_q.owner;
            end
        end
        if (i_cmd.evict && !r_placed) r_frame <= r_pick;
    end

    // Status and result
    assign o_sts.clr_last   = (r_idx == CNT_W'(CLR_DEPTH - 1));
    assign o_sts.way_done   = (r_idx == CNT_W'(WAYS));
    assign o_sts.frame_done = (r_idx == CNT_W'(FRAMES));
    assign o_sts.tlb_hit    = r_hit;
    assign o_sts.pt_hit     = r_pt_q.v;

    assign o_frame      = tlbpt_pkg::FRAME_OUT_W'(r_frame);
    assign o_tlb_hit    = r_hit;
    assign o_walk_hit   = r_thit;
    assign o_page_fault = r_fault;

    // A refill only follows a TLB miss
    a_fill_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> !r_hit)
        else $error("TLB refill after a hit");

    // A refill sees exactly one of table hit and fault
    a_fill_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> $onehot({r_thit, r_fault}))
        else $error("refill without a single table outcome");

    // Eviction needs a completed frame scan
    a_evict_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |-> (r_placed || r_hp))
        else $error("eviction without a scanned candidate");

    // Response flags never contradict each other
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_hit, r_thit, r_fault}))
        else $error("conflicting result flags");

endmodule

// ----- rtl/tlb_with_page_table_frame_alloc_core.sv -----
// Request accept to response valid: a TLB hit scans the ways of the set; a page table hit adds
// the table read and check and a TLB refill; a table miss also scans the frame records (one
// frame record a cycle), then runs the evict step and the refill. One transaction is in flight;
// the next can be accepted in the cycle after the response is taken.
// Reset (synchronous, active low) starts a clearing pass over max(2^VPN_BITS, FRAMES, TLB entries)
// entries (65536 by default) before the first request is accepted.
`timescale 1ns / 1ps

module tlb_with_page_table_frame_alloc_core #(
    parameter int VPN_BITS = 16,
    parameter int SET_BITS = 4,
    parameter int WAYS     = 4,
    parameter int FRAMES   = 256,
    parameter int AGE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlbpt_req_if.sink     i_req,
    tlbpt_rsp_if.source   o_rsp
);

    tlbpt_pkg::t_cmd cmd;
    tlbpt_pkg::t_sts sts;

    // Sequencer
    tlbpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Memories and scan datapath
    tlbpt_dp #(
        .VPN_BITS (VPN_BITS),
        .SET_BITS (SET_BITS),
        .WAYS     (WAYS),
        .FRAMES   (FRAMES),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vpn        (i_req.vpn),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_frame      (o_rsp.frame),
        .o_tlb_hit    (o_rsp.tlb_hit),
        .o_walk_hit   (o_rsp.walk_hit),
        .o_page_fault (o_rsp.page_fault)
    );

endmodule

// ----- verif/tlb_with_page_table_frame_alloc_core_test.sv -----
// Self-checking testbench of the TLB, page table and frame allocator block.
`timescale 1ns / 1ps

module tlb_with_page_table_frame_alloc_core_test;

    localparam int SETS       = 16;
    localparam int WAYS       = 4;
    localparam int FRAMES     = 256;
    localparam int PT_DEPTH   = 65536;
    localparam logic [15:0] AGE_TOP = 16'hFFFF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [tlbpt_pkg::FRAME_OUT_W-1:0] frame;
        logic                              tlb_hit;
        logic                              walk_hit;
        logic                              page_fault;
    } t_xlate;

    logic i_clk;
    logic i_rst_n;

    tlbpt_req_if req_if ();
    tlbpt_rsp_if rsp_if ();

    tlb_with_page_table_frame_alloc_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Shadow state of the translation path
    logic        sh_tlb_valid [SETS*WAYS];
    logic [11:0] sh_tlb_tag   [SETS*WAYS];
    logic [7:0]  sh_tlb_frame [SETS*WAYS];
    logic [15:0] sh_tlb_age   [SETS*WAYS];
    logic        sh_pt_valid  [PT_DEPTH];
    logic [7:0]  sh_pt_frame  [PT_DEPTH];
    logic        sh_fr_free   [FRAMES];
    logic [15:0] sh_fr_owner  [FRAMES];
    logic [15:0] sh_fr_age    [FRAMES];

    t_xlate expected_xlates [$];
    int     mismatches;
    int     cycles;
    int     n_tlb_hits, n_pt_hits, n_faults, n_evictions, n_sent;
    bit     hold_request;

    function automatic logic [15:0] age_up(logic [15:0] a);
        return (a == AGE_TOP) ? AGE_TOP : a + 16'd1;
    endfunction

    // Frame lookup on a TLB miss: table hit, free frame, or eviction of the oldest
    function automatic logic [7:0] walk_table(logic [15:0] vpn, output logic thit,
                                              output logic fault);
        int          pick;
        logic [15:0] best;
        bit          have_pick;
        bit          placed;
        int          got;
        pick = 0; best = '0; have_pick = 0; placed = 0; got = 0;
        if (sh_pt_valid[vpn]) begin
            thit = 1'b1;
            fault = 1'b0;
            return sh_pt_frame[vpn];
        end
        thit = 1'b0;
        fault = 1'b1;
        for (int i = 0; i < FRAMES; i++) begin
            if (sh_fr_free[i] && !placed) begin
                sh_fr_free[i] = 1'b0;
                sh_fr_owner[i] = vpn;
                sh_fr_age[i] = '0;
                got = i;
                placed = 1;
            end else begin
                if (!have_pick || sh_fr_age[i] > best) begin
                    best = sh_fr_age[i];
                    pick = i;
                    have_pick = 1;
                end
                sh_fr_age[i] = age_up(sh_fr_age[i]);
            end
        end
        if (!placed) begin
            // old owner loses its mapping; TLB copies stay
            sh_pt_valid[sh_fr_owner[pick]] = 1'b0;
            sh_fr_owner[pick] = vpn;
            sh_fr_age[pick] = '0;
            sh_fr_free[pick] = 1'b0;
            got = pick;
            n_evictions++;
        end
        sh_pt_valid[vpn] = 1'b1;
        sh_pt_frame[vpn] = got[7:0];
        return got[7:0];
    endfunction

    // Translation of one page, updating the shadow state
    function automatic t_xlate translate(logic [15:0] vpn);
        t_xlate      r;
        int          base;
        int          victim;
        logic [15:0] best;
        bit          have_victim;
        logic [11:0] tag;
        base = int'(vpn[3:0]) * WAYS;
        tag = vpn[15:4];
        victim = base; best = '0; have_victim = 0;
        r = '0;
        for (int w = base; w < base + WAYS; w++) begin
            if (!r.tlb_hit && sh_tlb_valid[w] && sh_tlb_tag[w] == tag) begin
                sh_tlb_age[w] = '0;
                r.frame = sh_tlb_frame[w];
                r.tlb_hit = 1'b1;
            end else begin
                sh_tlb_age[w] = age_up(sh_tlb_age[w]);
                if (!have_victim || sh_tlb_age[w] > best) begin
                    best = sh_tlb_age[w];
                    victim = w;
                    have_victim = 1;
                end
            end
        end
        if (!r.tlb_hit) begin
            r.frame = walk_table(vpn, r.walk_hit, r.page_fault);
            sh_tlb_age[victim] = '0;
            sh_tlb_frame[victim] = r.frame;
            sh_tlb_tag[victim] = tag;
            sh_tlb_valid[victim] = 1'b1;
        end
        if (r.tlb_hit) n_tlb_hits++;
        if (r.walk_hit) n_pt_hits++;
        if (r.page_fault) n_faults++;
        return r;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transactions pending",
                     cycles, expected_xlates.size());
            $display("tlb_with_page_table_frame_alloc_core_test: FAIL");
            $finish;
        end
    end

    // Response side: random ready gaps, one long hold on request, checks each transaction
    initial begin
        int     gap;
        t_xlate exp_x;
        t_xlate got_x;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (hold_request) begin
                gap = LONG_HOLD;
                hold_request = 0;
            end
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            got_x = '{rsp_if.frame, rsp_if.tlb_hit, rsp_if.walk_hit, rsp_if.page_fault};
            if (expected_xlates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: frame %0d tlb %b table %b fault %b",
                             got_x.frame, got_x.tlb_hit, got_x.walk_hit, got_x.page_fault);
            end else begin
                exp_x = expected_xlates.pop_front();
                if (got_x !== exp_x) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected frame %0d tlb %b table %b fault %b,",
                                  " got frame %0d tlb %b table %b fault %b"},
                                 exp_x.frame, exp_x.tlb_hit, exp_x.walk_hit,
                                 exp_x.page_fault, got_x.frame, got_x.tlb_hit,
                                 got_x.walk_hit, got_x.page_fault);
                end
            end
        end
    end

    // One request transaction after a given idle gap
    task automatic send_vpn(logic [15:0] vpn, int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.vpn   <= vpn;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_xlates.push_back(translate(vpn));
        n_sent++;
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    endfunction

    // Field extremes and repeats that must hit in the TLB
    task automatic test_extremes();
        send_vpn(16'h0000, 0);
        send_vpn(16'h0000, 1);
        send_vpn(16'hFFFF, 0);
        send_vpn(16'hFFFF, 3);
        send_vpn(16'hAAAA, 2);
        send_vpn(16'h5555, 0);
        send_vpn(16'hAAAA, 0);
    endtask

    // Six tags in one set: way replacement, table hits after TLB victimization
    task automatic test_set_conflict();
        for (int k = 0; k < 3; k++)
            for (int t = 0; t < 6; t++)
                send_vpn({12'(t * 12'h111), 4'h7}, draw_gap());
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_stall_pressure();
        hold_request = 1;
        for (int k = 0; k < 6; k++)
            send_vpn(16'(k * 16), 0);
    endtask

    // Mixed random traffic: hot pages, fresh pages, set conflicts
    task automatic test_random(int count);
        logic [15:0] hot [24];
        logic [15:0] v;
        int          r;
        foreach (hot[i]) hot[i] = 16'($urandom());
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (n % 300 == 299) hot[$urandom_range(0, 23)] = 16'($urandom());
            if (r < 55)
                v = hot[$urandom_range(0, 23)];
            else if (r < 75)
                v = 16'($urandom());
            else if (r < 92)
                v = {4'($urandom_range(0, 15)), 8'h00, hot[0][3:0]};
            else
                v = {12'($urandom()), 4'($urandom_range(0, 1))};
            send_vpn(v, draw_gap());
        end
    endtask

    // Shadow state after reset
    initial begin
        foreach (sh_tlb_valid[i]) begin
            sh_tlb_valid[i] = 1'b0;
            sh_tlb_age[i] = '0;
        end
        foreach (sh_pt_valid[i]) sh_pt_valid[i] = 1'b0;
        foreach (sh_fr_free[i]) begin
            sh_fr_free[i] = 1'b1;
            sh_fr_age[i] = '0;
        end
    end

    // Main sequence
    initial begin
        mismatches = 0;
        hold_request = 0;
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.vpn <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_set_conflict();
        test_stall_pressure();
        test_random(2000);

        req_if.valid <= 1'b0;
        while (expected_xlates.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("%0d translations: %0d TLB hits, %0d table hits, %0d faults, %0d evictions",
                 n_sent, n_tlb_hits, n_pt_hits, n_faults, n_evictions);
        $display("%0d mismatches, %0d cycles", mismatches, cycles);
        if (mismatches == 0 && expected_xlates.size() == 0) begin
            $display("tlb_with_page_table_frame_alloc_core_test: PASS");
        end else begin
            $display("tlb_with_page_table_frame_alloc_core_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tlbpt_pkg.sv
rtl/tlbpt_if.sv
rtl/tlbpt_ctrl.sv
rtl/tlbpt_dp.sv
rtl/tlb_with_page_table_frame_alloc_core.sv
verif/tlb_with_page_table_frame_alloc_core_test.sv
